FILE: hdl/chm_pkg.sv
// Package: sizes, command and status types for the chained hash map engine.
package chm_pkg;
    localparam int BUCKETS      = 256;
    localparam int POOL_ENTRIES = 1024;
    localparam int KEY_SHIFT    = 4;
    localparam int BW = $clog2(BUCKETS);
    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int IW = PW + 1;
    localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);

    localparam logic [1:0] MODE_GET = 2'd0;
    localparam logic [1:0] MODE_INS = 2'd1;
    localparam logic [1:0] MODE_SET = 2'd2;
    localparam logic [1:0] MODE_REM = 2'd3;

    typedef struct packed {
        logic load;       // capture input item, start head read
        logic cur_head;   // take bucket head as current
        logic rd_entry;   // issue entry read at current index
        logic step;       // advance to link of entry just read
        logic match;      // latch hit on entry just read
        logic wr_value;   // write value_in at hit entry
        logic alloc;      // allocate and push new entry
        logic unlink;     // unlink hit entry
        logic free_pop;   // read link of free head
        logic finish;     // load result register
    } t_cmd;

    typedef struct packed {
        logic cur_nil;    // current index is null
        logic hit;        // entry just read matches key
        logic free_nil;   // free list empty
        logic fresh_nil;  // no fresh entries left
        logic [1:0] mode;
    } t_sts;
endpackage

FILE: hdl/chm_datapath.sv
// Datapath: bucket heads, entry pool memories, free list and result register.
module chm_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  chm_pkg::t_cmd         i_cmd,
    output chm_pkg::t_sts         o_sts,
    input  logic [1:0]            i_mode,
    input  logic [63:0]           i_key,
    input  logic [63:0]           i_value_in,
    output logic                  o_found,
    output logic [63:0]           o_value_out,
    output logic                  o_full_res
);
    import chm_pkg::*;

    logic [IW-1:0] m_head [BUCKETS];
    logic [BUCKETS-1:0] r_head_vld;
    logic [63:0]   m_key  [POOL_ENTRIES];
    logic [63:0]   m_val  [POOL_ENTRIES];
    logic [IW-1:0] m_link [POOL_ENTRIES];

    logic [1:0]    r_mode;
    logic [63:0]   r_key, r_vin;
    logic [BW-1:0] r_bkt;
    logic [IW-1:0] r_head_rd, r_cur, r_prev, r_hit, r_hit_prev;
    logic          r_found;
    logic [63:0]   r_rkey, r_rval, r_hit_val;
    logic [IW-1:0] r_rlink, r_hit_link, r_free_link;
    logic [IW-1:0] r_free, r_fresh;
    logic          r_full;
    logic [BW-1:0] n_bkt;
    logic [IW-1:0] head_eff, new_ent;

    assign n_bkt    = i_key[KEY_SHIFT +: BW];
    assign head_eff = r_head_rd;
    assign new_ent  = (r_free != NIL) ? r_free : r_fresh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode; r_key <= i_key; r_vin <= i_value_in;
            r_bkt <= n_bkt;
            r_head_rd <= r_head_vld[n_bkt] ? m_head[n_bkt] : NIL;
            r_found <= 1'b0; r_full <= 1'b0;
        end
        if (i_cmd.cur_head) begin
            r_cur <= head_eff; r_prev <= NIL;
        end
        if (i_cmd.rd_entry) begin
            r_rkey  <= m_key[r_cur[PW-1:0]];
            r_rval  <= m_val[r_cur[PW-1:0]];
            r_rlink <= m_link[r_cur[PW-1:0]];
        end
        if (i_cmd.match) begin
            r_found <= 1'b1; r_hit <= r_cur; r_hit_prev <= r_prev;
            r_hit_val <= r_rval; r_hit_link <= r_rlink;
        end
        if (i_cmd.step) begin
            r_prev <= r_cur; r_cur <= r_rlink;
        end
        if (i_cmd.free_pop)
            r_free_link <= m_link[r_free[PW-1:0]];
        if (i_cmd.wr_value)
            m_val[r_hit[PW-1:0]] <= r_vin;
        // pool exhausted: store nothing
        if (i_cmd.alloc && new_ent != NIL) begin
            m_key[new_ent[PW-1:0]]  <= r_key;
            m_val[new_ent[PW-1:0]]  <= r_vin;
            m_link[new_ent[PW-1:0]] <= head_eff;
            m_head[r_bkt] <= new_ent;
        end
        if (i_cmd.unlink) begin
            if (r_hit_prev != NIL)
                m_link[r_hit_prev[PW-1:0]] <= r_hit_link;
            else
                m_head[r_bkt] <= r_hit_link;
            m_link[r_hit[PW-1:0]] <= r_free;
        end
        if (i_cmd.finish) begin
            o_found     <= r_found;
            o_value_out <= (r_found && r_mode != MODE_SET) ? r_hit_val : 64'd0;
            o_full_res  <= r_full;
        end
        if (i_cmd.alloc && new_ent == NIL) r_full <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= '0;
            r_free <= NIL;
            r_fresh <= '0;
        end else begin
            if (i_cmd.alloc && new_ent != NIL) begin
                r_head_vld[r_bkt] <= 1'b1;
                if (r_free != NIL) r_free <= r_free_link;
                else               r_fresh <= r_fresh + 1'b1;
            end
            if (i_cmd.unlink) begin
                r_head_vld[r_bkt] <= 1'b1;
                r_free <= r_hit;
            end
        end
    end

    assign o_sts.cur_nil   = (r_cur >= NIL);
    assign o_sts.hit       = (r_rkey == r_key);
    assign o_sts.free_nil  = (r_free == NIL);
    assign o_sts.fresh_nil = (r_fresh == NIL);
    assign o_sts.mode      = r_mode;
endmodule

FILE: hdl/chm_ctrl.sv
// Controller: sequences chain walk, update and result handoff.
module chm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  chm_pkg::t_sts i_sts,
    output chm_pkg::t_cmd o_cmd
);
    import chm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_HEAD = 3'd1, S_CHK = 3'd2, S_RD = 3'd3,
                           S_CMP = 3'd4, S_UPD = 3'd5, S_DONE = 3'd6;
    logic [2:0] r_state, n_state;
    logic       r_ovld, n_ovld;
    logic [IW:0] r_steps, n_steps;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_steps = r_steps;
        n_ovld = r_ovld && !i_out_ready;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1; n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.cur_head = 1'b1; n_steps = '0; n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.free_pop = !i_sts.free_nil;
                if (i_sts.cur_nil || r_steps >= (IW+1)'(POOL_ENTRIES)) n_state = S_UPD;
                else begin
                    o_cmd.rd_entry = 1'b1; n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.match = 1'b1; n_state = S_RD;
                end else begin
                    o_cmd.step = 1'b1; n_steps = r_steps + 1'b1; n_state = S_CHK;
                end
            end
            S_RD: begin
                n_state = S_DONE;
                unique case (i_sts.mode)
                    MODE_INS, MODE_SET: o_cmd.wr_value = 1'b1;
                    MODE_REM: o_cmd.unlink = 1'b1;
                    default: ;
                endcase
            end
            S_UPD: begin
                n_state = S_DONE;
                if (i_sts.mode == MODE_INS) o_cmd.alloc = 1'b1;
            end
            S_DONE: if (!r_ovld || i_out_ready) begin
                o_cmd.finish = 1'b1; n_ovld = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovld <= 1'b0; r_steps <= '0;
        end else begin
            r_state <= n_state; r_ovld <= n_ovld; r_steps <= n_steps;
        end
    end

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.alloc && o_cmd.unlink)) else $error("alloc and unlink together");
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_out_valid) else $error("result lost");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_HEAD) else $error("bad start");
endmodule

FILE: hdl/chained_hash_map_engine.sv
// Top level of the chained hash map engine.
// channel | dir | tdata fields (low bit up)             | tuser
// s_axis  | in  | mode[1:0], key[65:2], value_in[129:66] | -
// m_axis  | out | found[0], value_out[64:1], full_res[65] | -
// Chain walk does one entry read and one key compare per chain entry.
// Reset clears bucket valid bits, free list and fresh counter at once.
// The input stays stalled while an item is in work; a waiting result
// does not stop the next item from starting its walk.
module chained_hash_map_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,   // mode, key, value_in, zero pad
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata    // found, value_out, full_res, zero pad
);
    import chm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic found, full;
    logic [63:0] vout;

    chm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd)
    );

    chm_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_mode(s_axis_tdata[1:0]), .i_key(s_axis_tdata[65:2]),
        .i_value_in(s_axis_tdata[129:66]),
        .o_found(found), .o_value_out(vout), .o_full_res(full)
    );

    assign m_axis_tdata = {6'd0, full, vout, found};
endmodule
